@@ hdl/mcwq_pkg.sv @@
// ----------------------------------------------------------------------------
// mcwq_pkg
// Shared types and codes for the mutex and condition wait queue.
// ----------------------------------------------------------------------------
package mcwq_pkg;

    localparam int STATUS_W = 3;
    localparam int OPCODE_W = 2;

    typedef logic [STATUS_W-1:0] t_status;

    localparam t_status ST_GRANTED   = 3'd0;
    localparam t_status ST_QUEUED    = 3'd1;
    localparam t_status ST_DONE      = 3'd2;
    localparam t_status ST_NOT_OWNER = 3'd3;
    localparam t_status ST_FULL      = 3'd4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_OBTAIN  = 2'd0,
        OP_RELEASE = 2'd1,
        OP_WAIT    = 2'd2,
        OP_NOTIFY  = 2'd3
    } t_opcode;

    // Control shared by every waiter cell during a sweep.
    typedef struct packed {
        logic hand;   // 1: hand over to oldest plain waiter, 0: notify
        logic all;    // notify every matching waiter
    } t_sweep_ctl;

endpackage

@@ hdl/mcwq_cell.sv @@
// ----------------------------------------------------------------------------
// mcwq_cell
// One waiter slot. Acts when the sweep token reaches it, then passes the
// token, the found flag and the captured task to the next slot.
// ----------------------------------------------------------------------------
module mcwq_cell #(
    parameter int TASK_ID_WIDTH = 8,
    parameter int COND_WIDTH    = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  mcwq_pkg::t_sweep_ctl     i_ctl,
    input  logic [COND_WIDTH-1:0]    i_cond,
    input  logic                     i_wr,
    input  logic [TASK_ID_WIDTH-1:0] i_wr_task,
    input  logic                     i_wr_iscond,
    input  logic [COND_WIDTH-1:0]    i_wr_cond,
    input  logic                     i_nxt_valid,
    input  logic [TASK_ID_WIDTH-1:0] i_nxt_task,
    input  logic                     i_nxt_iscond,
    input  logic [COND_WIDTH-1:0]    i_nxt_cond,
    input  logic                     i_tok,
    input  logic                     i_tok_flag,
    input  logic [TASK_ID_WIDTH-1:0] i_tok_task,
    output logic                     o_valid,
    output logic [TASK_ID_WIDTH-1:0] o_task,
    output logic                     o_iscond,
    output logic [COND_WIDTH-1:0]    o_cond,
    output logic                     o_tok,
    output logic                     o_tok_flag,
    output logic [TASK_ID_WIDTH-1:0] o_tok_task,
    output logic                     o_hit
);
    import mcwq_pkg::*;

    logic                     r_valid;
    logic [TASK_ID_WIDTH-1:0] r_task;
    logic                     r_iscond;
    logic [COND_WIDTH-1:0]    r_cond;
    logic                     r_tok;
    logic                     r_tok_flag;
    logic [TASK_ID_WIDTH-1:0] r_tok_task;

    logic w_plain;
    logic w_match;
    logic w_hand_hit;
    logic w_shift;

    assign w_plain    = r_valid && !r_iscond;
    assign w_match    = r_valid && r_iscond && (r_cond == i_cond) && (i_ctl.all || !i_tok_flag);
    assign w_hand_hit = i_ctl.hand && !i_tok_flag && w_plain;
    assign o_hit      = i_tok && (i_ctl.hand ? w_hand_hit : w_match);
    assign w_shift    = i_tok && i_ctl.hand && (i_tok_flag || w_plain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_tok   <= 1'b0;
        end else begin
            r_tok <= i_tok;
            if (i_wr) begin
                r_valid <= 1'b1;
            end else if (w_shift) begin
                r_valid <= i_nxt_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_flag <= i_tok_flag || o_hit;
        r_tok_task <= (i_tok && w_hand_hit) ? r_task : i_tok_task;
        if (i_wr) begin
            r_task   <= i_wr_task;
            r_iscond <= i_wr_iscond;
            r_cond   <= i_wr_cond;
        end else if (w_shift) begin
            r_task   <= i_nxt_task;
            r_iscond <= i_nxt_iscond;
            r_cond   <= i_nxt_cond;
        end else if (i_tok && !i_ctl.hand && w_match) begin
            r_iscond <= 1'b0;
        end
    end

    assign o_valid    = r_valid;
    assign o_task     = r_task;
    assign o_iscond   = r_iscond;
    assign o_cond     = r_cond;
    assign o_tok      = r_tok;
    assign o_tok_flag = r_tok_flag;
    assign o_tok_task = r_tok_task;

endmodule

@@ hdl/mutex_condition_wait_queue.sv @@
// ----------------------------------------------------------------------------
// mutex_condition_wait_queue
// Lock unit for one FIFO mutex with condition waiters, built as a chain of
// waiter cells swept by a token.
//
//   channel   | handshake                  | payload
//   ----------+----------------------------+-------------------------------
//   request   | i_in_valid / o_in_ready    | opcode, task_id, cond,
//             |                            | notify_all
//   result    | o_out_valid / i_out_ready  | status, woken_valid, woken_task,
//             |                            | notified_count, owner_valid,
//             |                            | owner_task
//
// Obtain, failed and rejected requests pass from accept through the execute
// and finish states to the output register. Release and notify sweep the
// token once along the chain, one cell visited per cycle. Wait writes its
// entry in the cycle before the sweep starts.
// One request at a time; the next is taken in the cycle after the result is
// loaded, even while it waits in the output register. Reset is synchronous
// and empties the queue at once.
// ----------------------------------------------------------------------------
module mutex_condition_wait_queue #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TASK_ID_WIDTH = 8,
    parameter int COND_WIDTH    = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [mcwq_pkg::OPCODE_W-1:0]        i_opcode,
    input  logic [TASK_ID_WIDTH-1:0]             i_task_id,
    input  logic [COND_WIDTH-1:0]                i_cond,
    input  logic                                 i_notify_all,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic [mcwq_pkg::STATUS_W-1:0]        o_status,
    output logic                                 o_woken_valid,
    output logic [TASK_ID_WIDTH-1:0]             o_woken_task,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_notified_count,
    output logic                                 o_owner_valid,
    output logic [TASK_ID_WIDTH-1:0]             o_owner_task
);
    import mcwq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SWEEP,
        S_FIN
    } t_state;

    t_state                   r_state;
    t_opcode                  r_op;
    logic [TASK_ID_WIDTH-1:0] r_task;
    logic [COND_WIDTH-1:0]    r_cond;
    logic                     r_all;
    logic                     r_held;
    logic [TASK_ID_WIDTH-1:0] r_holder;
    logic [CNT_W-1:0]         r_count;
    logic                     r_start;
    logic                     r_enq;
    logic                     r_enq_cond;
    t_sweep_ctl               r_ctl;
    t_status                  r_status;
    logic                     r_woke;
    logic [TASK_ID_WIDTH-1:0] r_woken;
    logic [CNT_W-1:0]         r_ncnt;

    logic                     r_out_valid;
    t_status                  r_o_status;
    logic                     r_o_woke;
    logic [TASK_ID_WIDTH-1:0] r_o_woken;
    logic [CNT_W-1:0]         r_o_ncnt;
    logic                     r_o_held;
    logic [TASK_ID_WIDTH-1:0] r_o_holder;

    logic                     w_valid  [0:QUEUE_DEPTH];
    logic [TASK_ID_WIDTH-1:0] w_etask  [0:QUEUE_DEPTH];
    logic                     w_iscond [0:QUEUE_DEPTH];
    logic [COND_WIDTH-1:0]    w_econd  [0:QUEUE_DEPTH];
    logic                     w_tok    [0:QUEUE_DEPTH];
    logic                     w_flag   [0:QUEUE_DEPTH];
    logic [TASK_ID_WIDTH-1:0] w_ttask  [0:QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0]   w_hit;

    logic w_accept;
    logic w_owner;
    logic w_full;
    logic w_out_free;

    assign w_accept   = i_in_valid && o_in_ready;
    assign w_owner    = r_held && (r_holder == r_task);
    assign w_full     = (r_count == CNT_W'(QUEUE_DEPTH));
    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign w_tok[0]   = r_start;
    assign w_flag[0]  = 1'b0;
    assign w_ttask[0] = '0;

    assign w_valid[QUEUE_DEPTH]  = 1'b0;
    assign w_etask[QUEUE_DEPTH]  = '0;
    assign w_iscond[QUEUE_DEPTH] = 1'b0;
    assign w_econd[QUEUE_DEPTH]  = '0;

    for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
        logic w_wr;
        assign w_wr = r_enq && (r_count == CNT_W'(k + 1));

        mcwq_cell #(
            .TASK_ID_WIDTH(TASK_ID_WIDTH),
            .COND_WIDTH   (COND_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (r_ctl),
            .i_cond      (r_cond),
            .i_wr        (w_wr),
            .i_wr_task   (r_task),
            .i_wr_iscond (r_enq_cond),
            .i_wr_cond   (r_cond),
            .i_nxt_valid (w_valid[k+1]),
            .i_nxt_task  (w_etask[k+1]),
            .i_nxt_iscond(w_iscond[k+1]),
            .i_nxt_cond  (w_econd[k+1]),
            .i_tok       (w_tok[k]),
            .i_tok_flag  (w_flag[k]),
            .i_tok_task  (w_ttask[k]),
            .o_valid     (w_valid[k]),
            .o_task      (w_etask[k]),
            .o_iscond    (w_iscond[k]),
            .o_cond      (w_econd[k]),
            .o_tok       (w_tok[k+1]),
            .o_tok_flag  (w_flag[k+1]),
            .o_tok_task  (w_ttask[k+1]),
            .o_hit       (w_hit[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= 1'b0;
            r_holder    <= '0;
            r_count     <= '0;
            r_start     <= 1'b0;
            r_enq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            r_enq   <= 1'b0;
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= t_opcode'(i_opcode);
                        r_task  <= i_task_id;
                        r_cond  <= i_cond;
                        r_all   <= i_notify_all;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_woke     <= 1'b0;
                    r_woken    <= '0;
                    r_ncnt     <= '0;
                    r_enq_cond <= (r_op == OP_WAIT);
                    r_ctl.hand <= (r_op != OP_NOTIFY);
                    r_ctl.all  <= r_all;
                    r_state    <= S_FIN;
                    unique case (r_op)
                        OP_OBTAIN: begin
                            if (!r_held) begin
                                r_held   <= 1'b1;
                                r_holder <= r_task;
                                r_status <= ST_GRANTED;
                            end else if (w_owner) begin
                                r_status <= ST_GRANTED;
                            end else if (w_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_enq    <= 1'b1;
                                r_count  <= r_count + CNT_W'(1);
                                r_status <= ST_QUEUED;
                            end
                        end
                        OP_RELEASE: begin
                            if (!w_owner) begin
                                r_status <= ST_NOT_OWNER;
                            end else begin
                                r_status <= ST_DONE;
                                r_start  <= 1'b1;
                                r_state  <= S_SWEEP;
                            end
                        end
                        OP_WAIT: begin
                            if (!w_owner) begin
                                r_status <= ST_NOT_OWNER;
                            end else if (w_full) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_enq    <= 1'b1;
                                r_count  <= r_count + CNT_W'(1);
                                r_status <= ST_QUEUED;
                                r_state  <= S_SWEEP;
                            end
                        end
                        OP_NOTIFY: begin
                            r_status <= ST_DONE;
                            r_start  <= 1'b1;
                            r_state  <= S_SWEEP;
                        end
                        default: begin
                            r_status <= ST_DONE;
                        end
                    endcase
                end
                S_SWEEP: begin
                    if (r_enq) begin
                        r_start <= 1'b1;
                    end
                    if (|w_hit) begin
                        r_ncnt <= r_ncnt + CNT_W'(1);
                    end
                    if (w_tok[QUEUE_DEPTH]) begin
                        r_state <= S_FIN;
                        if (r_ctl.hand) begin
                            if (w_flag[QUEUE_DEPTH]) begin
                                r_woke   <= 1'b1;
                                r_woken  <= w_ttask[QUEUE_DEPTH];
                                r_holder <= w_ttask[QUEUE_DEPTH];
                                r_count  <= r_count - CNT_W'(1);
                            end else begin
                                r_held   <= 1'b0;
                                r_holder <= '0;
                            end
                            r_ncnt <= '0;
                        end
                    end
                end
                S_FIN: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_woke    <= r_woke;
                        r_o_woken   <= r_woken;
                        r_o_ncnt    <= r_ncnt;
                        r_o_held    <= r_held;
                        r_o_holder  <= r_held ? r_holder : '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_o_status;
    assign o_woken_valid    = r_o_woke;
    assign o_woken_task     = r_o_woken;
    assign o_notified_count = r_o_ncnt;
    assign o_owner_valid    = r_o_held;
    assign o_owner_task     = r_o_holder;

endmodule

@@ hdl/mcwq_checker.sv @@
// ----------------------------------------------------------------------------
// mcwq_checker
// Port-level checks on the mutex and condition wait queue requests and results.
// ----------------------------------------------------------------------------
module mcwq_checker #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int TASK_ID_WIDTH = 8,
    parameter int COND_WIDTH    = 32
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_ready,
    input logic [mcwq_pkg::OPCODE_W-1:0]        i_opcode,
    input logic [TASK_ID_WIDTH-1:0]             i_task_id,
    input logic [COND_WIDTH-1:0]                i_cond,
    input logic                                 i_notify_all,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic [mcwq_pkg::STATUS_W-1:0]        o_status,
    input logic                                 o_woken_valid,
    input logic [TASK_ID_WIDTH-1:0]             o_woken_task,
    input logic [$clog2(QUEUE_DEPTH+1)-1:0]     o_notified_count,
    input logic                                 o_owner_valid,
    input logic [TASK_ID_WIDTH-1:0]             o_owner_task
);
    import mcwq_pkg::*;

    logic w_req_seen;
    assign w_req_seen = i_in_valid && o_in_ready && (i_opcode != '1 || i_notify_all ||
                        i_cond != '0 || i_task_id != '0 || 1'b1);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status))
        else $error("result dropped while stalled");

    a_free_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_owner_valid |-> o_owner_task == '0)
        else $error("free lock reports an owner");

    a_woken_owns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_woken_valid |->
            o_owner_valid && o_owner_task == o_woken_task &&
            (o_status == ST_DONE || o_status == ST_QUEUED))
        else $error("woken task does not own the lock");

    a_reject_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == ST_NOT_OWNER || o_status == ST_FULL) |->
            !o_woken_valid && o_notified_count == '0)
        else $error("rejected request had side effects");

    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_seen |=> !o_in_ready)
        else $error("request taken while another is in flight");

endmodule

bind mutex_condition_wait_queue mcwq_checker #(
    .QUEUE_DEPTH  (QUEUE_DEPTH),
    .TASK_ID_WIDTH(TASK_ID_WIDTH),
    .COND_WIDTH   (COND_WIDTH)
) u_mcwq_checker (.*);
